FILE: src/pcc_pkg.sv
// Shared types for the polygon containment checker: beat payloads, request
// codes, controller states and the command and status bundles.
// No dependencies.
package pcc_pkg;

   typedef enum logic [1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_APPEND = 2'd1,
      FUNC_TEST   = 2'd2
   } func_type;

   typedef struct packed {
      logic [1:0]         func;
      logic [2:0]         ring_index;
      logic signed [31:0] x_coord;
      logic signed [31:0] y_coord;
   } req_type;

   typedef struct packed {
      logic        inside_boundary;
      logic        in_exclusion;
      logic [31:0] outside_total;
      logic [31:0] excluded_total;
      logic        status;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_RING,
      ST_PREV,
      ST_EDGE,
      ST_DIFF,
      ST_MUL,
      ST_CMP,
      ST_RINGEND,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      RD_LAST,
      RD_CUR,
      RD_NEXT
   } rd_sel_type;

   typedef struct packed {
      logic       latch;
      logic       clear;
      logic       append;
      logic       test_init;
      logic       ring_setup;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       prev_load;
      logic       edge_load;
      logic       skip_adv;
      logic       diff_load;
      logic       mul_en;
      logic [2:0] mul_step;
      logic       cmp_adv;
      logic       ring_end;
      logic       ring_next;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       short_ring;
      logic       straddle;
      logic       last_edge;
      logic       last_ring;
      logic       out_free;
   } stat_type;

endpackage

FILE: src/pcc_ctrl.sv
// Controller for the polygon containment checker: sequences the ring and
// edge walk and the multiply steps. Depends on pcc_pkg.
module pcc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pcc_pkg::stat_type stat,
   output pcc_pkg::cmd_type  cmd
);
   import pcc_pkg::*;

   state_type  state_ff, state_in;
   logic [2:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd          = '0;
      cmd.rd_sel   = RD_CUR;
      cmd.mul_step = step_ff;
      req_stall    = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (stat.func)
               FUNC_CLEAR: begin
                  cmd.clear = 1'b1;
                  state_in  = ST_DONE;
               end
               FUNC_APPEND: begin
                  cmd.append = 1'b1;
                  state_in   = ST_DONE;
               end
               FUNC_TEST: begin
                  cmd.test_init = 1'b1;
                  state_in      = ST_RING;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_RING: begin
            cmd.ring_setup = 1'b1;
            if (stat.short_ring) begin
               state_in = ST_RINGEND;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_LAST;
               state_in   = ST_PREV;
            end
         end
         ST_PREV: begin
            cmd.prev_load = 1'b1;
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = RD_CUR;
            state_in      = ST_EDGE;
         end
         ST_EDGE: begin
            if (stat.straddle) begin
               cmd.edge_load = 1'b1;
               state_in      = ST_DIFF;
            end else begin
               cmd.skip_adv = 1'b1;
               if (stat.last_edge) begin
                  state_in = ST_RINGEND;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_NEXT;
               end
            end
         end
         ST_DIFF: begin
            cmd.diff_load = 1'b1;
            step_in       = '0;
            state_in      = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            step_in    = step_ff + 3'd1;
            if (step_ff == 3'd7) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            cmd.cmp_adv = 1'b1;
            if (stat.last_edge) begin
               state_in = ST_RINGEND;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_NEXT;
               state_in   = ST_EDGE;
            end
         end
         ST_RINGEND: begin
            cmd.ring_end = 1'b1;
            if (stat.last_ring) begin
               state_in = ST_DONE;
            end else begin
               cmd.ring_next = 1'b1;
               state_in      = ST_RING;
            end
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

FILE: src/pcc_dpath.sv
// Datapath for the polygon containment checker: vertex memories, ring
// lengths, edge crossing arithmetic, counters and the result register.
// Depends on pcc_pkg.
module pcc_dpath #(
   parameter int MAX_RINGS = 8,
   parameter int MAX_VERTS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  pcc_pkg::req_type  req_data,
   input  pcc_pkg::cmd_type  cmd,
   output pcc_pkg::stat_type stat,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pcc_pkg::rsp_type  rsp_data
);
   import pcc_pkg::*;

   localparam int RW    = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1;
   localparam int EW    = ((RW > 3) ? RW : 3) + 1;
   localparam int LW    = $clog2(MAX_VERTS + 1);
   localparam int VW    = $clog2(MAX_VERTS);
   localparam int DEPTH = MAX_RINGS * MAX_VERTS;
   localparam int AW    = $clog2(DEPTH);

   function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r,
                                             input logic [VW-1:0] v);
      return AW'(AW'(r) * AW'(MAX_VERTS)) + AW'(v);
   endfunction

   logic [31:0]        mem_x [DEPTH];
   logic [31:0]        mem_y [DEPTH];
   logic signed [31:0] rd_x_ff, rd_y_ff;

   req_type            req_ff;
   logic [LW-1:0]      len_ff [MAX_RINGS];
   logic [31:0]        outside_ff, excluded_ff;
   logic [RW-1:0]      r_ff;
   logic [LW-1:0]      v_ff;
   logic               inside_ff, in_b_ff, in_e_ff, drop_ff;
   logic signed [31:0] prev_x_ff, prev_y_ff;
   logic signed [31:0] xa_ff, ya_ff, xb_ff, yb_ff;
   logic [32:0]        mag_p_ff, mag_e_ff;
   logic               neg_p_ff, neg_e_ff;
   logic [31:0]        dyb_ff, dyp_ff;
   logic [65:0]        lhs_ff, rhs_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic [EW-1:0]      ring_ext;
   logic [RW-1:0]      ring_ix;
   logic               ring_ok, app_ok;
   logic [LW-1:0]      app_len, cur_len, len_m1, v_next;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [VW-1:0]      rd_v;
   logic               y_cur_up, y_prev_up, cur_low;
   logic signed [32:0] px_e, xa_e, xb_e, py_e, ya_e, yb_e;
   logic [32:0]        dyb_w, dyp_w;
   logic [32:0]        mul_a;
   logic [31:0]        mul_b;
   logic [16:0]        a_part;
   logic [15:0]        b_part;
   logic [32:0]        prod;
   logic [65:0]        pp, acc_base;
   logic               na, nb, less;
   logic [31:0]        outside_in, excluded_in;

   // Append addressing; an append to an out-of-range or full ring is dropped and writes nothing.
   assign ring_ext = EW'(req_ff.ring_index);
   assign ring_ok  = ring_ext < EW'(MAX_RINGS);
   assign ring_ix  = ring_ext[RW-1:0];
   assign app_len  = len_ff[ring_ix];
   assign app_ok   = ring_ok && (app_len < LW'(MAX_VERTS));
   assign wr_addr  = addr_of(ring_ix, app_len[VW-1:0]);

   assign cur_len = len_ff[r_ff];
   assign len_m1  = cur_len - LW'(1);
   assign v_next  = v_ff + LW'(1);

   always_comb begin
      unique case (cmd.rd_sel)
         RD_LAST: rd_v = len_m1[VW-1:0];
         RD_NEXT: rd_v = v_next[VW-1:0];
         default: rd_v = v_ff[VW-1:0];
      endcase
   end
   assign rd_addr = addr_of(r_ff, rd_v);

   always_ff @(posedge clock) begin
      if (cmd.append && app_ok) begin
         mem_x[wr_addr] <= req_ff.x_coord;
         mem_y[wr_addr] <= req_ff.y_coord;
      end
      if (cmd.rd_en) begin
         rd_x_ff <= mem_x[rd_addr];
         rd_y_ff <= mem_y[rd_addr];
      end
   end

   // An edge counts when exactly one end lies strictly above the point.
   assign y_cur_up  = rd_y_ff > req_ff.y_coord;
   assign y_prev_up = prev_y_ff > req_ff.y_coord;
   assign cur_low   = rd_y_ff < prev_y_ff;

   assign px_e  = 33'(req_ff.x_coord);
   assign py_e  = 33'(req_ff.y_coord);
   assign xa_e  = 33'(xa_ff);
   assign xb_e  = 33'(xb_ff);
   assign ya_e  = 33'(ya_ff);
   assign yb_e  = 33'(yb_ff);
   assign dyb_w = 33'(yb_e - ya_e);
   assign dyp_w = 33'(py_e - ya_e);

   // Exact 33x32 magnitude products built from four 17x16 partials each.
   assign mul_a    = cmd.mul_step[2] ? mag_e_ff : mag_p_ff;
   assign mul_b    = cmd.mul_step[2] ? dyp_ff : dyb_ff;
   assign a_part   = cmd.mul_step[0] ? mul_a[32:16] : {1'b0, mul_a[15:0]};
   assign b_part   = cmd.mul_step[1] ? mul_b[31:16] : mul_b[15:0];
   assign prod     = 33'(a_part) * 33'(b_part);
   assign acc_base = (cmd.mul_step[1:0] == 2'd0) ? '0
                     : (cmd.mul_step[2] ? rhs_ff : lhs_ff);

   always_comb begin
      unique case (cmd.mul_step[1:0])
         2'd0:    pp = 66'(prod);
         2'd3:    pp = 66'(prod) << 32;
         default: pp = 66'(prod) << 16;
      endcase
   end

   // Signed comparison of the two products; a zero product carries no sign.
   assign na   = neg_p_ff && (lhs_ff != '0);
   assign nb   = neg_e_ff && (rhs_ff != '0);
   assign less = (na != nb) ? na : (na ? (lhs_ff > rhs_ff) : (lhs_ff < rhs_ff));

   always_comb begin
      outside_in  = outside_ff;
      excluded_in = excluded_ff;
      if (req_ff.func == FUNC_TEST) begin
         if (!in_b_ff && (outside_ff != '1)) begin
            outside_in = outside_ff + 32'd1;
         end
         if (in_e_ff && (excluded_ff != '1)) begin
            excluded_in = excluded_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         req_ff  <= req_data;
         drop_ff <= 1'b0;
      end
      if (cmd.append && !app_ok) begin
         drop_ff <= 1'b1;
      end
      if (cmd.test_init) begin
         r_ff    <= '0;
         in_b_ff <= 1'b0;
         in_e_ff <= 1'b0;
      end
      if (cmd.ring_setup) begin
         v_ff      <= '0;
         inside_ff <= 1'b0;
      end
      if (cmd.prev_load) begin
         prev_x_ff <= rd_x_ff;
         prev_y_ff <= rd_y_ff;
      end
      if (cmd.edge_load) begin
         if (cur_low) begin
            xa_ff <= rd_x_ff;   ya_ff <= rd_y_ff;
            xb_ff <= prev_x_ff; yb_ff <= prev_y_ff;
         end else begin
            xa_ff <= prev_x_ff; ya_ff <= prev_y_ff;
            xb_ff <= rd_x_ff;   yb_ff <= rd_y_ff;
         end
         prev_x_ff <= rd_x_ff;
         prev_y_ff <= rd_y_ff;
      end
      if (cmd.skip_adv) begin
         prev_x_ff <= rd_x_ff;
         prev_y_ff <= rd_y_ff;
         v_ff      <= v_next;
      end
      if (cmd.diff_load) begin
         neg_p_ff <= px_e < xa_e;
         mag_p_ff <= (px_e < xa_e) ? 33'(xa_e - px_e) : 33'(px_e - xa_e);
         neg_e_ff <= xb_e < xa_e;
         mag_e_ff <= (xb_e < xa_e) ? 33'(xa_e - xb_e) : 33'(xb_e - xa_e);
         dyb_ff   <= dyb_w[31:0];
         dyp_ff   <= dyp_w[31:0];
      end
      if (cmd.mul_en) begin
         if (cmd.mul_step[2]) begin
            rhs_ff <= acc_base + pp;
         end else begin
            lhs_ff <= acc_base + pp;
         end
      end
      if (cmd.cmp_adv) begin
         if (less) begin
            inside_ff <= !inside_ff;
         end
         v_ff <= v_next;
      end
      if (cmd.ring_end) begin
         if (r_ff == '0) begin
            in_b_ff <= inside_ff;
         end else if (inside_ff) begin
            in_e_ff <= 1'b1;
         end
      end
      if (cmd.ring_next) begin
         r_ff <= r_ff + RW'(1);
      end
      if (cmd.finish) begin
         rsp_ff.inside_boundary <= in_b_ff && (req_ff.func == FUNC_TEST);
         rsp_ff.in_exclusion    <= in_e_ff && (req_ff.func == FUNC_TEST);
         rsp_ff.outside_total   <= outside_in;
         rsp_ff.excluded_total  <= excluded_in;
         rsp_ff.status          <= drop_ff && (req_ff.func == FUNC_APPEND);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_RINGS; i++) begin
            len_ff[i] <= '0;
         end
         outside_ff   <= '0;
         excluded_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            for (int i = 0; i < MAX_RINGS; i++) begin
               len_ff[i] <= '0;
            end
            outside_ff  <= '0;
            excluded_ff <= '0;
         end
         if (cmd.append && app_ok) begin
            len_ff[ring_ix] <= app_len + LW'(1);
         end
         if (cmd.finish) begin
            outside_ff   <= outside_in;
            excluded_ff  <= excluded_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.func       = req_ff.func;
   assign stat.short_ring = cur_len < LW'(3);
   assign stat.straddle   = y_cur_up != y_prev_up;
   assign stat.last_edge  = v_next == cur_len;
   assign stat.last_ring  = r_ff == RW'(MAX_RINGS - 1);
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: src/polygon_containment_checker.sv
// Top level of the polygon containment checker: controller plus datapath.
// Depends on pcc_pkg, pcc_ctrl and pcc_dpath.
//
// Request beats (req_valid/req_stall/req_data) clear all rings and counts,
// append one vertex to a ring, or test a point. Each request yields exactly
// one response beat (rsp_valid/rsp_stall/rsp_data) from an output register.
// Requests are taken one at a time: req_stall is low only while the block
// is idle. A test walks every edge of every ring of three or more vertices
// in order; for each edge that spans the point's y, two exact 66-bit
// products are built from four partial products each on one shared
// multiplier. A new request is accepted while the previous response still
// waits in the output register; the block then holds its next response
// until the receiver lowers rsp_stall. Reset empties every ring, zeroes
// both counts and drops any pending response; vertex memory is not
// cleared, since only entries below a ring's length are read.
module polygon_containment_checker #(
   parameter int MAX_RINGS = 8,
   parameter int MAX_VERTS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pcc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pcc_pkg::rsp_type rsp_data
);
   import pcc_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   pcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pcc_dpath #(
      .MAX_RINGS (MAX_RINGS),
      .MAX_VERTS (MAX_VERTS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: verif/pcc_checker.sv
// Checker for the polygon containment checker: watches the request and response
// channels, predicts each response beat and compares it. Depends on pcc_pkg.
`timescale 1ns / 100ps
module pcc_checker #(
   parameter int MAX_RINGS = 8,
   parameter int MAX_VERTS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  pcc_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  pcc_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_count,
   output int               tests_seen,
   output int               hits_seen
);
   import pcc_pkg::*;

   logic signed [31:0] vx [MAX_RINGS*MAX_VERTS];
   logic signed [31:0] vy [MAX_RINGS*MAX_VERTS];
   int unsigned        ring_len [MAX_RINGS];
   logic [31:0]        outside_cnt, excluded_cnt;
   rsp_type            expected_rsps [$];

   // Exact even-odd test: (px-xa)*(yb-ya) < (xb-xa)*(py-ya) on 68-bit products.
   function automatic bit ring_holds(int r, logic signed [31:0] px, logic signed [31:0] py);
      bit                 parity;
      int                 j;
      logic signed [33:0] dxp, dxe, dyp, dye;
      logic signed [67:0] lhs, rhs;
      logic signed [31:0] xa, ya, xb, yb, xi, yi, xj, yj;
      parity = 0;
      if (ring_len[r] < 3) return 0;
      j = ring_len[r] - 1;
      for (int i = 0; i < ring_len[r]; i++) begin
         xi = vx[r*MAX_VERTS+i]; yi = vy[r*MAX_VERTS+i];
         xj = vx[r*MAX_VERTS+j]; yj = vy[r*MAX_VERTS+j];
         if ((yi > py) != (yj > py)) begin
            if (yi < yj) begin
               xa = xi; ya = yi; xb = xj; yb = yj;
            end else begin
               xa = xj; ya = yj; xb = xi; yb = yi;
            end
            dxp = 34'(px) - 34'(xa);
            dxe = 34'(xb) - 34'(xa);
            dye = 34'(yb) - 34'(ya);
            dyp = 34'(py) - 34'(ya);
            lhs = 68'(dxp) * 68'(dye);
            rhs = 68'(dxe) * 68'(dyp);
            if (lhs < rhs) parity = !parity;
         end
         j = i;
      end
      return parity;
   endfunction

   function automatic rsp_type predict_containment(req_type rq);
      rsp_type rs;
      rs = '0;
      case (rq.func)
         FUNC_CLEAR: begin
            foreach (ring_len[r]) ring_len[r] = 0;
            outside_cnt = 0;
            excluded_cnt = 0;
         end
         FUNC_APPEND: begin
            if (rq.ring_index >= MAX_RINGS || ring_len[rq.ring_index] >= MAX_VERTS) begin
               rs.status = 1;
            end else begin
               vx[rq.ring_index*MAX_VERTS + ring_len[rq.ring_index]] = rq.x_coord;
               vy[rq.ring_index*MAX_VERTS + ring_len[rq.ring_index]] = rq.y_coord;
               ring_len[rq.ring_index]++;
            end
         end
         FUNC_TEST: begin
            rs.inside_boundary = ring_holds(0, rq.x_coord, rq.y_coord);
            for (int r = 1; r < MAX_RINGS; r++)
               if (ring_holds(r, rq.x_coord, rq.y_coord)) rs.in_exclusion = 1;
            if (!rs.inside_boundary && outside_cnt != '1) outside_cnt++;
            if (rs.in_exclusion && excluded_cnt != '1) excluded_cnt++;
         end
         default: ;
      endcase
      rs.outside_total = outside_cnt;
      rs.excluded_total = excluded_cnt;
      return rs;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (ring_len[r]) ring_len[r] = 0;
         outside_cnt = 0;
         excluded_cnt = 0;
         expected_rsps.delete();
         fail_count = 0;
         tests_seen = 0;
         hits_seen = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response beat %h", $time, rsp_data);
               fail_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.inside_boundary !== want.inside_boundary)
                  $display("%0t: inside_boundary expected %0d actual %0d", $time,
                           want.inside_boundary, rsp_data.inside_boundary);
               if (rsp_data.in_exclusion !== want.in_exclusion)
                  $display("%0t: in_exclusion expected %0d actual %0d", $time,
                           want.in_exclusion, rsp_data.in_exclusion);
               if (rsp_data.outside_total !== want.outside_total)
                  $display("%0t: outside_total expected %0d actual %0d", $time,
                           want.outside_total, rsp_data.outside_total);
               if (rsp_data.excluded_total !== want.excluded_total)
                  $display("%0t: excluded_total expected %0d actual %0d", $time,
                           want.excluded_total, rsp_data.excluded_total);
               if (rsp_data.status !== want.status)
                  $display("%0t: status expected %0d actual %0d", $time,
                           want.status, rsp_data.status);
               if (rsp_data !== want) fail_count++;
            end
         end
         if (req_valid && !req_stall) begin
            want = predict_containment(req_data);
            expected_rsps = {expected_rsps, want};
            if (req_data.func == FUNC_TEST) begin
               tests_seen++;
               if (want.inside_boundary || want.in_exclusion) hits_seen++;
            end
         end
      end
      pending_count = expected_rsps.size();
   end

   initial begin
      fail_count = 0;
      pending_count = 0;
      tests_seen = 0;
      hits_seen = 0;
   end
endmodule

FILE: verif/tb_polygon_containment_checker.sv
// Testbench top for the polygon containment checker: drives request beats,
// throttles responses and reports the verdict. Depends on pcc_pkg and pcc_checker.
`timescale 1ns / 100ps
module tb_polygon_containment_checker;
   import pcc_pkg::*;

   localparam int N_RINGS = 8;
   localparam int N_VERTS = 64;
   localparam int RANDOM_BEATS = 800;

   logic    clock, reset;
   logic    req_valid, req_stall, rsp_valid, rsp_stall;
   req_type req_data;
   rsp_type rsp_data;
   int      fail_count, pending_count, tests_seen, hits_seen;
   bit      quiet_tail, long_hold;

   polygon_containment_checker #(.MAX_RINGS(N_RINGS), .MAX_VERTS(N_VERTS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   pcc_checker #(.MAX_RINGS(N_RINGS), .MAX_VERTS(N_VERTS)) checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count),
      .tests_seen(tests_seen), .hits_seen(hits_seen)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Send one request beat and hold it until accepted, sometimes with a random gap after.
   task automatic send_beat(logic [1:0] fn, logic [2:0] ring, logic [31:0] x, logic [31:0] y);
      req_data <= {fn, ring, x, y};
      req_valid <= 1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
   endtask

   function automatic logic [31:0] rand_coord(int span);
      return (span == 0) ? $urandom : $signed($urandom_range(0, 2*span)) - span;
   endfunction

   task automatic drain_all();
      req_valid <= 0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // Append a small ring of random vertices to a random ring; the caller then sends test points.
   task automatic build_shape(int span);
      int ring, nv;
      ring = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, N_RINGS - 1);
      nv = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 8);
      for (int k = 0; k < nv; k++)
         send_beat(FUNC_APPEND, 3'(ring), rand_coord(span), rand_coord(span));
   endtask

   // Response side: random stall bursts, one long hold-off on request.
   initial begin
      rsp_stall = 0;
      @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1;
            repeat (400) @(negedge clock);
            rsp_stall <= 0;
            long_hold = 0;
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1;
            repeat ($urandom_range(1, 5)) @(negedge clock);
         end else begin
            rsp_stall <= 0;
            @(negedge clock);
         end
      end
   end

   initial begin
      int sent, span;
      logic [1:0] fn;
      reset = 1;
      req_valid = 0;
      req_data = '0;
      quiet_tail = 0;
      long_hold = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: empty boundary, unused code, short ring, extremes, full ring.
      send_beat(FUNC_TEST, 0, 0, 0);
      send_beat(2'd3, 7, 32'h8000_0000, 32'h7fff_ffff);
      send_beat(FUNC_APPEND, 0, 32'h8000_0000, 32'h8000_0000);
      send_beat(FUNC_APPEND, 0, 32'h7fff_ffff, 32'h8000_0000);
      send_beat(FUNC_TEST, 0, 0, 0);
      send_beat(FUNC_APPEND, 0, 32'h7fff_ffff, 32'h7fff_ffff);
      send_beat(FUNC_APPEND, 0, 32'h8000_0000, 32'h7fff_ffff);
      send_beat(FUNC_TEST, 0, 0, 0);
      send_beat(FUNC_TEST, 0, 32'h8000_0000, 32'h8000_0000);
      send_beat(FUNC_TEST, 0, 32'h7fff_ffff, 32'h7fff_fffe);
      send_beat(FUNC_APPEND, 7, -5, -5);
      send_beat(FUNC_APPEND, 7, 5, -5);
      send_beat(FUNC_APPEND, 7, 5, -5);
      send_beat(FUNC_APPEND, 7, 0, 5);
      send_beat(FUNC_TEST, 0, 0, 0);
      send_beat(FUNC_TEST, 0, 0, -5);
      send_beat(FUNC_TEST, 0, -6, 0);
      for (int k = 0; k < N_VERTS + 1; k++)
         send_beat(FUNC_APPEND, 3, k, k * k);
      send_beat(FUNC_TEST, 0, 10, 50);
      send_beat(FUNC_CLEAR, 0, 0, 0);
      send_beat(FUNC_TEST, 0, 1, 1);

      // The block queues one response; the long hold-off fills it up.
      long_hold = 1;
      for (int k = 0; k < 6; k++) send_beat(FUNC_TEST, 0, $urandom, $urandom);
      drain_all();

      sent = 0;
      while (sent < RANDOM_BEATS) begin
         if (sent > RANDOM_BEATS * 9 / 10) quiet_tail = 1;
         span = $urandom_range(0, 2) == 0 ? 0 : 1 << $urandom_range(2, 20);
         if ($urandom_range(0, 5) == 0) begin
            fn = 2'($urandom_range(0, 3));
            send_beat(fn, 3'($urandom), $urandom, $urandom);
            sent++;
         end else begin
            if ($urandom_range(0, 4) == 0) begin
               send_beat(FUNC_CLEAR, 3'($urandom), $urandom, $urandom);
               sent++;
            end
            build_shape(span);
            sent += 5;
            for (int k = 0; k < 6; k++) begin
               send_beat(FUNC_TEST, 3'($urandom), rand_coord(span), rand_coord(span));
               sent++;
            end
         end
         if (!quiet_tail && $urandom_range(0, 60) == 0) drain_all();
      end

      drain_all();
      repeat (6000) @(negedge clock);
      $display("Covered %0d test points, %0d of them inside a ring, plus clears, appends",
               tests_seen, hits_seen);
      $display("and unused codes under random stalls on both channels.");
      if (fail_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #400ms;
      $display("simulation failed");
      $finish;
   end
endmodule
